// ----- rtl/crd_pkg.sv -----
// Shared constants and types for the camera ray direction block.
package crd_pkg;

	localparam int CFG_W         = 18;
	localparam int IN_W          = 19;
	localparam int OUT_W         = 18;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NORM_BITS     = 30;
	localparam int ROOT_W        = 31;
	localparam int MAG_W         = 31;
	localparam int LANES         = 3;

	localparam logic [CFG_W-1:0] ONE_RESET = CFG_W'(65536);
	localparam logic [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_COS_PITCH = 2'd0,
		REG_SIN_PITCH = 2'd1,
		REG_COS_YAW   = 2'd2,
		REG_SIN_YAW   = 2'd3
	} reg_index_t;

endpackage

// ----- rtl/crd_sqrt_cell.sv -----
// One root digit of the integer square root chain, carrying the lane words along.
module crd_sqrt_cell import crd_pkg::*; #(
	parameter int RW = ROOT_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             up_valid,
	input  logic [2*RW-1:0]                  up_rad,
	input  logic [RW+2:0]                    up_rem,
	input  logic [RW-1:0]                    up_root,
	input  logic [LANES-1:0][MAG_W-1:0]      up_mag,
	input  logic [LANES-1:0]                 up_neg,
	output logic                             dn_valid,
	output logic [2*RW-1:0]                  dn_rad,
	output logic [RW+2:0]                    dn_rem,
	output logic [RW-1:0]                    dn_root,
	output logic [LANES-1:0][MAG_W-1:0]      dn_mag,
	output logic [LANES-1:0]                 dn_neg
);

	localparam int SW  = 2 * RW;
	localparam int RMW = RW + 3;

	logic [RMW-1:0]               rem_sh;
	logic [RMW-1:0]               trial;
	logic                         ge;
	logic                         valid_q;
	logic [SW-1:0]                rad_q;
	logic [RMW-1:0]               rem_q;
	logic [RW-1:0]                root_q;
	logic [LANES-1:0][MAG_W-1:0]  mag_q;
	logic [LANES-1:0]             neg_q;

	// bring down the next radicand pair and try 4r+1
	always_comb begin
		rem_sh = {up_rem[RMW-3:0], up_rad[SW-1:SW-2]};
		trial  = RMW'({up_root, 2'b01});
		ge     = (rem_sh >= trial);
	end

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	// hold the partial root and remainder
	always_ff @(posedge clk) begin
		rad_q  <= {up_rad[SW-3:0], 2'b00};
		rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		root_q <= {up_root[RW-2:0], ge};
		mag_q  <= up_mag;
		neg_q  <= up_neg;
	end

	assign dn_valid = valid_q;
	assign dn_rad   = rad_q;
	assign dn_rem   = rem_q;
	assign dn_root  = root_q;
	assign dn_mag   = mag_q;
	assign dn_neg   = neg_q;

endmodule

// ----- rtl/crd_div_cell.sv -----
// One quotient bit of the restoring divider, three lanes sharing one divisor.
module crd_div_cell import crd_pkg::*; #(
	parameter int QTW = FRAC_BITS_DEF + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           up_valid,
	input  logic [ROOT_W-1:0]              up_len,
	input  logic [LANES-1:0][ROOT_W:0]     up_rem,
	input  logic [LANES-1:0][QTW-1:0]      up_quo,
	input  logic [LANES-1:0]               up_neg,
	output logic                           dn_valid,
	output logic [ROOT_W-1:0]              dn_len,
	output logic [LANES-1:0][ROOT_W:0]     dn_rem,
	output logic [LANES-1:0][QTW-1:0]      dn_quo,
	output logic [LANES-1:0]               dn_neg
);

	localparam int DRW = ROOT_W + 1;

	logic [LANES-1:0]             ge;
	logic [LANES-1:0][DRW-1:0]    rem_nx;
	logic [LANES-1:0][DRW-1:0]    diff;
	logic                         valid_q;
	logic [ROOT_W-1:0]            len_q;
	logic [LANES-1:0][DRW-1:0]    rem_q;
	logic [LANES-1:0][QTW-1:0]    quo_q;
	logic [LANES-1:0]             neg_q;

	// compare, subtract and shift each lane
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			ge[i]     = (up_rem[i] >= {1'b0, up_len});
			diff[i]   = ge[i] ? (up_rem[i] - {1'b0, up_len}) : up_rem[i];
			rem_nx[i] = {diff[i][DRW-2:0], 1'b0};
		end
	end

	// advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= up_valid;
		end
	end

	// hold the partial quotients
	always_ff @(posedge clk) begin
		len_q <= up_len;
		neg_q <= up_neg;
		for (int i = 0; i < LANES; i++) begin
			rem_q[i] <= rem_nx[i];
			quo_q[i] <= {up_quo[i][QTW-2:0], ge[i]};
		end
	end

	assign dn_valid = valid_q;
	assign dn_len   = len_q;
	assign dn_rem   = rem_q;
	assign dn_quo   = quo_q;
	assign dn_neg   = neg_q;

endmodule

// ----- rtl/camera_ray_direction.sv -----
// Top level of the pinhole camera ray direction generator.
// Takes one screen offset word per clock (busy is always low) and returns the unit ray
// direction with done high for one cycle; results come out in order and cannot be held
// off. The pipeline holds seven arithmetic stages, a chain of 31 square root cells (one
// root bit each) and a chain of FRAC_BITS+1 divider cells (one quotient bit each), plus
// the output register.
module camera_ray_direction import crd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [IN_W-1:0]   screen_u,
	input  logic signed [IN_W-1:0]   screen_v,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     done,
	output logic signed [OUT_W-1:0]  dir_x,
	output logic signed [OUT_W-1:0]  dir_y,
	output logic signed [OUT_W-1:0]  dir_z
);

	localparam int PW  = 38 - FRAC_BITS;
	localparam int P2F = 57 - 2 * FRAC_BITS;
	localparam int P2W = (P2F > 2) ? P2F : 2;
	localparam int XW1 = (PW > P2W) ? PW : P2W;
	localparam int XW  = (XW1 > CFG_W) ? XW1 : CFG_W;
	localparam int DW  = XW + 2;
	localparam int KW  = $clog2(DW);
	localparam int SW  = 2 * ROOT_W;
	localparam int QTW = FRAC_BITS + 1;
	localparam int DRW = ROOT_W + 1;
	localparam int EW  = ((QTW > OUT_W) ? QTW : OUT_W) + 1;
	localparam int LAT = 7 + ROOT_W + QTW + 1;
	localparam logic [EW-1:0]    NEG_LIM = EW'(2 ** (OUT_W - 1));
	localparam logic [EW-1:0]    POS_LIM = EW'(2 ** (OUT_W - 1) - 1);
	localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(2 ** NORM_BITS);

	// configuration registers
	logic signed [CFG_W-1:0] cos_pitch_q, sin_pitch_q, cos_yaw_q, sin_yaw_q;

	// stage 1 products
	logic signed [2*CFG_W-1:0]    m_cc, m_cs, m_sc, m_ss;
	logic signed [IN_W+CFG_W-1:0] m_usy, m_vcp;
	logic signed [CFG_W:0]        ncy;
	logic signed [IN_W+CFG_W:0]   m_uncy;
	logic                         vld_s1;
	logic signed [PW-1:0]         p_cc_s1, p_cs_s1, nsc_s1, nss_s1, usy_s1, uncy_s1, vcp_s1;
	logic signed [IN_W-1:0]       v_s1;
	logic signed [CFG_W-1:0]      sp_s1;

	// stage 2 products
	logic signed [IN_W+PW-1:0]    m_vsc, m_vss;
	logic                         vld_s2;
	logic signed [PW-1:0]         p_cc_s2, p_cs_s2, usy_s2, uncy_s2, vcp_s2;
	logic signed [P2W-1:0]        vsc_s2, vss_s2;
	logic signed [CFG_W-1:0]      sp_s2;

	// stage 3 sums, stage 4 scale, stage 5 magnitudes
	logic                         vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [DW-1:0]         d_s3 [LANES];
	logic [DW-1:0]                am [LANES];
	logic [DW-1:0]                orm;
	logic [KW-1:0]                k_nx;
	logic signed [DW-1:0]         d_s4 [LANES];
	logic [KW-1:0]                k_s4;
	logic signed [DW-1:0]         sh [LANES];
	logic signed [MAG_W:0]        ds [LANES];
	logic signed [MAG_W:0]        dm [LANES];
	logic [LANES-1:0][MAG_W-1:0]  mag_s5, mag_s6, mag_s7;
	logic [LANES-1:0]             neg_s5, neg_s6, neg_s7;
	logic [SW-1:0]                sq_s6 [LANES];
	logic [SW-1:0]                sum_s7;

	// square root chain
	logic                         sq_valid [ROOT_W+1];
	logic [SW-1:0]                sq_rad   [ROOT_W+1];
	logic [ROOT_W+2:0]            sq_rem   [ROOT_W+1];
	logic [ROOT_W-1:0]            sq_root  [ROOT_W+1];
	logic [LANES-1:0][MAG_W-1:0]  sq_mag   [ROOT_W+1];
	logic [LANES-1:0]             sq_neg   [ROOT_W+1];

	// divider chain
	logic                         dv_valid [QTW+1];
	logic [ROOT_W-1:0]            dv_len   [QTW+1];
	logic [LANES-1:0][DRW-1:0]    dv_rem   [QTW+1];
	logic [LANES-1:0][QTW-1:0]    dv_quo   [QTW+1];
	logic [LANES-1:0]             dv_neg   [QTW+1];

	// output
	logic [EW-1:0]                qe [LANES];
	logic [EW-1:0]                qn [LANES];
	logic [OUT_W-1:0]             res [LANES];
	logic                         done_q;
	logic [OUT_W-1:0]             dir_x_q, dir_y_q, dir_z_q;

	// take a configuration word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_pitch_q <= ONE_RESET;
			sin_pitch_q <= '0;
			cos_yaw_q   <= ONE_RESET;
			sin_yaw_q   <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_COS_PITCH: cos_pitch_q <= cfg_data;
				REG_SIN_PITCH: sin_pitch_q <= cfg_data;
				REG_COS_YAW:   cos_yaw_q   <= cfg_data;
				REG_SIN_YAW:   sin_yaw_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: basis products and the products with u and v
	always_comb begin
		m_cc   = cos_pitch_q * cos_yaw_q;
		m_cs   = cos_pitch_q * sin_yaw_q;
		m_sc   = sin_pitch_q * cos_yaw_q;
		m_ss   = sin_pitch_q * sin_yaw_q;
		m_usy  = screen_u * sin_yaw_q;
		m_vcp  = screen_v * cos_pitch_q;
		ncy    = -((CFG_W+1)'(cos_yaw_q));
		m_uncy = screen_u * ncy;
	end

	// stage 2 products of v with the negated up terms
	always_comb begin
		m_vsc = v_s1 * nsc_s1;
		m_vss = v_s1 * nss_s1;
	end

	// magnitudes and shift from the stage 3 sums
	always_comb begin
		orm  = '0;
		k_nx = '0;
		for (int i = 0; i < LANES; i++) begin
			am[i] = d_s3[i][DW-1] ? DW'(-d_s3[i]) : DW'(d_s3[i]);
			orm   = orm | am[i];
		end
		// find the shift that brings the largest magnitude below the norm limit
		for (int i = NORM_BITS; i < DW; i++) begin
			if (orm[i]) begin
				k_nx = KW'(i - NORM_BITS + 1);
			end
		end
	end

	// stage 5 scaling and magnitudes
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sh[i] = d_s4[i] >>> k_s4;
			ds[i] = (MAG_W+1)'(sh[i]);
			dm[i] = ds[i][MAG_W] ? -ds[i] : ds[i];
		end
	end

	// advance the valid flags of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// front stage words
	always_ff @(posedge clk) begin
		p_cc_s1 <= PW'(m_cc >>> FRAC_BITS);
		p_cs_s1 <= PW'(m_cs >>> FRAC_BITS);
		nsc_s1  <= -PW'(m_sc >>> FRAC_BITS);
		nss_s1  <= -PW'(m_ss >>> FRAC_BITS);
		usy_s1  <= PW'(m_usy >>> FRAC_BITS);
		uncy_s1 <= PW'(m_uncy >>> FRAC_BITS);
		vcp_s1  <= PW'(m_vcp >>> FRAC_BITS);
		v_s1    <= screen_v;
		sp_s1   <= sin_pitch_q;

		p_cc_s2 <= p_cc_s1;
		p_cs_s2 <= p_cs_s1;
		usy_s2  <= usy_s1;
		uncy_s2 <= uncy_s1;
		vcp_s2  <= vcp_s1;
		sp_s2   <= sp_s1;
		vsc_s2  <= P2W'(m_vsc >>> FRAC_BITS);
		vss_s2  <= P2W'(m_vss >>> FRAC_BITS);

		d_s3[0] <= DW'(p_cc_s2) + DW'(usy_s2) + DW'(vsc_s2);
		d_s3[1] <= DW'(sp_s2) + DW'(vcp_s2);
		d_s3[2] <= DW'(p_cs_s2) + DW'(uncy_s2) + DW'(vss_s2);

		d_s4 <= d_s3;
		k_s4 <= k_nx;

		for (int i = 0; i < LANES; i++) begin
			mag_s5[i] <= dm[i][MAG_W-1:0];
			neg_s5[i] <= ds[i][MAG_W];
			sq_s6[i]  <= SW'(mag_s5[i]) * SW'(mag_s5[i]);
		end
		mag_s6 <= mag_s5;
		neg_s6 <= neg_s5;

		sum_s7 <= sq_s6[0] + sq_s6[1] + sq_s6[2];
		mag_s7 <= mag_s6;
		neg_s7 <= neg_s6;
	end

	// feed the square root chain
	assign sq_valid[0] = vld_s7;
	assign sq_rad[0]   = sum_s7;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_mag[0]   = mag_s7;
	assign sq_neg[0]   = neg_s7;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
		crd_sqrt_cell #(
			.RW(ROOT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (sq_valid[g]),
			.up_rad   (sq_rad[g]),
			.up_rem   (sq_rem[g]),
			.up_root  (sq_root[g]),
			.up_mag   (sq_mag[g]),
			.up_neg   (sq_neg[g]),
			.dn_valid (sq_valid[g+1]),
			.dn_rad   (sq_rad[g+1]),
			.dn_rem   (sq_rem[g+1]),
			.dn_root  (sq_root[g+1]),
			.dn_mag   (sq_mag[g+1]),
			.dn_neg   (sq_neg[g+1])
		);
	end

	// feed the divider chain: magnitude over length
	assign dv_valid[0] = sq_valid[ROOT_W];
	assign dv_len[0]   = sq_root[ROOT_W];
	assign dv_neg[0]   = sq_neg[ROOT_W];
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			dv_rem[0][i] = {1'b0, sq_mag[ROOT_W][i]};
			dv_quo[0][i] = '0;
		end
	end

	for (genvar g = 0; g < QTW; g++) begin : g_div
		crd_div_cell #(
			.QTW(QTW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (dv_valid[g]),
			.up_len   (dv_len[g]),
			.up_rem   (dv_rem[g]),
			.up_quo   (dv_quo[g]),
			.up_neg   (dv_neg[g]),
			.dn_valid (dv_valid[g+1]),
			.dn_len   (dv_len[g+1]),
			.dn_rem   (dv_rem[g+1]),
			.dn_quo   (dv_quo[g+1]),
			.dn_neg   (dv_neg[g+1])
		);
	end

	// apply the sign and saturate; a zero length gives a zero word
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			qe[i] = EW'(dv_quo[QTW][i]);
			qn[i] = -qe[i];
			if (dv_len[QTW] == '0) begin
				res[i] = '0;
			end else if (dv_neg[QTW][i]) begin
				res[i] = (qe[i] > NEG_LIM) ? OUT_MIN : qn[i][OUT_W-1:0];
			end else begin
				res[i] = (qe[i] > POS_LIM) ? OUT_MAX : qe[i][OUT_W-1:0];
			end
		end
	end

	// drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid[QTW];
		end
	end

	// hold the result word
	always_ff @(posedge clk) begin
		dir_x_q <= res[0];
		dir_y_q <= res[1];
		dir_z_q <= res[2];
	end

	assign done  = done_q;
	assign dir_x = dir_x_q;
	assign dir_y = dir_y_q;
	assign dir_z = dir_z_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result word without a start at the fixed latency");

	a_scaled: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (mag_s5[0] <= MAG_LIM && mag_s5[1] <= MAG_LIM && mag_s5[2] <= MAG_LIM))
		else $error("scaled component above the norm limit");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_valid[QTW] && dv_len[QTW] != '0) |->
		(dv_rem[QTW][0] < {dv_len[QTW], 1'b0} && dv_rem[QTW][1] < {dv_len[QTW], 1'b0}
		&& dv_rem[QTW][2] < {dv_len[QTW], 1'b0}))
		else $error("divider remainder out of range");
`endif

endmodule

// ----- tb/tb_camera_ray_direction.sv -----
// Self-checking testbench for the camera ray direction block.
`timescale 1ns / 100ps

module tb_camera_ray_direction;
	import crd_pkg::*;

	localparam int FB      = FRAC_BITS_DEF;
	localparam int LAT     = FB + 40;
	localparam int WD_MAX  = 2000;
	localparam int N_RAND  = 1000;

	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} dir_t;

	typedef struct {
		logic signed [IN_W-1:0] u;
		logic signed [IN_W-1:0] v;
		bit                     typed;
		dir_t                   ref_dir;
	} row_t;

	logic clk, arst_n, start, busy, cfg_we, done;
	logic signed [IN_W-1:0] screen_u, screen_v;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic signed [OUT_W-1:0] dir_x, dir_y, dir_z;

	// local copy of the basis registers
	logic signed [CFG_W-1:0] cam_cp, cam_sp, cam_cy, cam_sy;

	dir_t dir_queue[$];
	int   errors, words_in, words_out, idle_cycles;

	camera_ray_direction DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint fshift(longint a, int s);
		return a >>> s;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return fshift(a * b, FB);
	endfunction

	function automatic longint isqrt(longint s);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(longint q);
		if (q > 131071) return OUT_MAX;
		if (q < -131072) return OUT_MIN;
		return q[OUT_W-1:0];
	endfunction

	// compute the normalized direction through one screen point
	function automatic dir_t ray_dir(logic signed [IN_W-1:0] su, logic signed [IN_W-1:0] sv);
		longint cp, sp, cy, sy, u, v, m, sum, len;
		longint d[3];
		int k;
		dir_t r;
		cp = cam_cp; sp = cam_sp; cy = cam_cy; sy = cam_sy; u = su; v = sv;
		d[0] = fmul(cp, cy) + fmul(u, sy) + fmul(v, -fmul(sp, cy));
		d[1] = sp + fmul(v, cp);
		d[2] = fmul(cp, sy) + fmul(u, -cy) + fmul(v, -fmul(sp, sy));
		m = 0;
		for (int i = 0; i < 3; i++) if ((d[i] < 0 ? -d[i] : d[i]) > m) m = d[i] < 0 ? -d[i] : d[i];
		k = 0;
		while (m >= (64'sd1 << NORM_BITS)) begin
			m = m >> 1;
			k++;
		end
		for (int i = 0; i < 3; i++) d[i] = fshift(d[i], k);
		sum = 0;
		for (int i = 0; i < 3; i++) sum += d[i] * d[i];
		len = isqrt(sum);
		for (int i = 0; i < 3; i++) d[i] = (len != 0) ? (d[i] * (64'sd1 << FB)) / len : 0;
		r.x = sat_out(d[0]);
		r.y = sat_out(d[1]);
		r.z = sat_out(d[2]);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s at result %0d: got %0d want %0d", what, words_out, got, want);
		errors++;
	endtask

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (dir_queue.size() == 0) begin
				$display("unexpected result word %0d", words_out);
				errors++;
			end else begin
				dir_t e;
				e = dir_queue.pop_front();
				if (dir_x !== e.x) report_mismatch("dir_x", dir_x, e.x);
				if (dir_y !== e.y) report_mismatch("dir_y", dir_y, e.y);
				if (dir_z !== e.z) report_mismatch("dir_z", dir_z, e.z);
			end
			words_out++;
		end
	end

	// watchdog on cycles with no accepted or returned word
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_MAX) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(reg_index_t idx, logic signed [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COS_PITCH: cam_cp = val;
			REG_SIN_PITCH: cam_sp = val;
			REG_COS_YAW:   cam_cy = val;
			REG_SIN_YAW:   cam_sy = val;
			default: ;
		endcase
	endtask

	task automatic set_camera(int cp, int sp, int cy, int sy);
		write_reg(REG_COS_PITCH, CFG_W'(cp));
		write_reg(REG_SIN_PITCH, CFG_W'(sp));
		write_reg(REG_COS_YAW, CFG_W'(cy));
		write_reg(REG_SIN_YAW, CFG_W'(sy));
	endtask

	// issue one screen word with a given expectation; held until accepted
	task automatic send_expect(logic signed [IN_W-1:0] u, logic signed [IN_W-1:0] v,
		dir_t want);
		start    <= 1'b1;
		screen_u <= u;
		screen_v <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		dir_queue.push_back(want);
		words_in++;
		@(negedge clk);
	endtask

	// issue one screen word checked against the predictor
	task automatic send_point(logic signed [IN_W-1:0] u, logic signed [IN_W-1:0] v);
		send_expect(u, v, ray_dir(u, v));
	endtask

	task automatic gap(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (dir_queue.size() != 0) @(negedge clk);
		repeat (LAT + 4) @(negedge clk);
	endtask

	function automatic logic signed [IN_W-1:0] rand_in();
		case ($urandom_range(0, 5))
			0: return 131072;
			1: return -131072;
			2: return IN_W'($urandom_range(0, 262143));
			default: return IN_W'($signed(19'($urandom_range(0, 4096))) - 2048);
		endcase
	endfunction

	function automatic logic signed [CFG_W-1:0] rand_cfg();
		case ($urandom_range(0, 3))
			0: return 65536;
			1: return -65536;
			default: return CFG_W'($signed(18'($urandom_range(0, 131072))) - 65536);
		endcase
	endfunction

	row_t rows[$];
	int   burst;

	initial begin
		row_t r;
		dir_t z;
		words_in = 0;
		start = 0; screen_u = 0; screen_v = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		cam_cp = ONE_RESET; cam_sp = 0; cam_cy = ONE_RESET; cam_sy = 0;
		arst_n = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed rows under reset basis: center looks straight along x
		z.x = 65536; z.y = 0; z.z = 0;
		r.u = 0; r.v = 0; r.typed = 1; r.ref_dir = z; rows.push_back(r);
		r.typed = 0;
		r.u = 131072;  r.v = 0;       rows.push_back(r);
		r.u = -131072; r.v = 0;       rows.push_back(r);
		r.u = 0;       r.v = 131072;  rows.push_back(r);
		r.u = 0;       r.v = -131072; rows.push_back(r);
		r.u = 131072;  r.v = 131072;  rows.push_back(r);
		r.u = -131072; r.v = -131072; rows.push_back(r);
		r.u = 19'sh3ffff; r.v = -19'sh40000; rows.push_back(r);
		r.u = 1;       r.v = -1;      rows.push_back(r);
		foreach (rows[i]) begin
			if (rows[i].typed)
				send_expect(rows[i].u, rows[i].v, rows[i].ref_dir);
			else
				send_point(rows[i].u, rows[i].v);
		end
		drain();

		// zero basis gives a zero vector at the center
		set_camera(0, 0, 0, 0);
		send_point(0, 0);
		send_point(131072, -131072);
		drain();
		// extreme negative basis
		set_camera(-65536, -65536, -65536, -65536);
		send_point(0, 0); send_point(131072, 131072); send_point(-131072, 131072);
		drain();
		set_camera(65536, 65536, 65536, 65536);
		send_point(-131072, -131072); send_point(131072, 0);
		drain();

		// random phases with new camera settings between them
		for (int ph = 0; ph < 8; ph++) begin
			set_camera(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
			for (int n = 0; n < N_RAND / 8; ) begin
				burst = $urandom_range(1, 30);
				for (int b = 0; b < burst && n < N_RAND / 8; b++, n++)
					send_point(rand_in(), rand_in());
				if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 12));
			end
			drain();
		end

		$display("sent %0d screen words, checked %0d ray directions", words_in, words_out);
		$display("covered reset, zero, extreme and random camera bases");
		if (errors == 0 && dir_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/crd_pkg.sv
rtl/crd_sqrt_cell.sv
rtl/crd_div_cell.sv
rtl/camera_ray_direction.sv
tb/tb_camera_ray_direction.sv
